// File: sv/tce_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the Takagi curve evaluator.
// Used by tce_ctrl, tce_datapath, the top level and the checker.
package tce_pkg;

  localparam int unsigned MaxTermsDefault      = 50;
  localparam int unsigned PointFracBitsDefault = 48;

  localparam int unsigned PhaseW    = 64;
  localparam int unsigned RatioW    = 32;
  localparam int unsigned ValueW    = 38;
  localparam int unsigned TermW     = 33;
  localparam int unsigned CountW    = 7;
  localparam int unsigned CountOutW = 6;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [PhaseW-1:0] WeightFloor = 64'd1845;
  localparam logic [RatioW-1:0] RatioReset  = 32'h8000_0000;

  typedef enum logic [0:0] {
    REG_WEIGHT_RATIO = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic sum_en;
    logic acc_en;
  } tce_cmd_t;

  typedef struct packed {
    logic last;
  } tce_status_t;

endpackage

// File: sv/tce_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the Takagi curve evaluator: steps each term through
// multiply and sum cycles. Depends on tce_pkg.
module tce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic                 done_o,
  output tce_pkg::tce_cmd_t    cmd_o,
  input  tce_pkg::tce_status_t status_i
);
  import tce_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   acc_q, acc_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    acc_d   = 1'b0;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        acc_d   = 1'b1;
        state_d = status_i.last ? ST_FLUSH : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_SUM;
      end
      ST_FLUSH: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o.load   = (state_q == ST_IDLE) && start_i;
  assign cmd_o.mul_en = (state_q == ST_MUL);
  assign cmd_o.sum_en = (state_q == ST_SUM);
  assign cmd_o.acc_en = acc_q;

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// File: sv/tce_datapath.sv
`timescale 1ns / 1ps
// Datapath of the Takagi curve evaluator: phase shifter, triangle fold,
// 32x32 partial products, weight update and saturating sum. Uses tce_pkg.
module tce_datapath #(
  parameter int unsigned MAX_TERMS       = tce_pkg::MaxTermsDefault,
  parameter int unsigned POINT_FRAC_BITS = tce_pkg::PointFracBitsDefault
) (
  input  logic                             clk_i,
  input  tce_pkg::tce_cmd_t                cmd_i,
  output tce_pkg::tce_status_t             status_o,
  input  logic [POINT_FRAC_BITS-1:0]       point_i,
  input  logic [tce_pkg::RatioW-1:0]       ratio_i,
  output logic [tce_pkg::ValueW-1:0]       curve_value_o,
  output logic [tce_pkg::CountOutW-1:0]    terms_used_o
);
  import tce_pkg::*;

  function automatic logic [PhaseW-1:0] fold_phase(input logic [PhaseW-1:0] t);
    fold_phase = t[PhaseW-1] ? (~t + 64'd1) : t;
  endfunction

  logic [PhaseW-1:0]   phase_q, tri_q, wt_q;
  logic [PhaseW-1:0]   p00_q, p01_q, p10_q, p11_q;
  logic [PhaseW-1:0]   pw_lo_q, pw_hi_q;
  logic [TermW-1:0]    term_q;
  logic [ValueW-1:0]   acc_q;
  logic [CountW-1:0]   count_q;
  logic                first_q;

  logic [PhaseW-1:0]   phase_in, phase_next, wt_d;
  logic [2*PhaseW-1:0] prod_sum;
  logic [TermW-1:0]    term_d;
  logic [ValueW:0]     acc_sum;

  assign phase_in   = PhaseW'(point_i) << (PhaseW - POINT_FRAC_BITS);
  assign phase_next = {phase_q[PhaseW-2:0], 1'b0};

  assign prod_sum = {p11_q, p00_q}
                  + {32'b0, p01_q, 32'b0}
                  + {32'b0, p10_q, 32'b0};

  assign term_d = first_q ? tri_q[PhaseW-1:31] : prod_sum[2*PhaseW-1:95];
  assign wt_d   = first_q ? {ratio_i, 32'b0}
                          : pw_hi_q + {32'b0, pw_lo_q[PhaseW-1:32]};

  assign status_o.last = (wt_d < WeightFloor) || (count_q == CountW'(MAX_TERMS - 1));

  assign acc_sum = {1'b0, acc_q} + (ValueW + 1)'(term_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p00_q   <= wt_q[31:0]  * tri_q[31:0];
      p01_q   <= wt_q[31:0]  * tri_q[63:32];
      p10_q   <= wt_q[63:32] * tri_q[31:0];
      p11_q   <= wt_q[63:32] * tri_q[63:32];
      pw_lo_q <= wt_q[31:0]  * ratio_i;
      pw_hi_q <= wt_q[63:32] * ratio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      phase_q <= phase_in;
      tri_q   <= fold_phase(phase_in);
      acc_q   <= '0;
      count_q <= '0;
      first_q <= 1'b1;
    end else begin
      if (cmd_i.sum_en) begin
        term_q  <= term_d;
        wt_q    <= wt_d;
        phase_q <= phase_next;
        tri_q   <= fold_phase(phase_next);
        count_q <= count_q + CountW'(1);
        first_q <= 1'b0;
      end
      if (cmd_i.acc_en) begin
        acc_q <= acc_sum[ValueW] ? '1 : acc_sum[ValueW-1:0];
      end
    end
  end

  assign curve_value_o = acc_q;
  assign terms_used_o  = count_q[CountOutW-1:0];

endmodule

// File: sv/takagi_curve_evaluator_core.sv
`timescale 1ns / 1ps
// Top level of the Takagi curve evaluator: APB ratio register, sequencer
// and datapath. Depends on tce_pkg, tce_ctrl and tce_datapath.
//
//   channel   handshake               word
//   input     start & !busy           point_i
//   result    done_o (one cycle)      curve_value_o, terms_used_o
//   config    psel&penable&pwrite     pwdata -> weight_ratio (paddr 0)
//
// An item keeps busy high through a sum state for its first term, then a
// multiply and a sum state per further term (one shared set of 32x32
// multipliers), and a flush state that folds in the last term. done_o
// pulses in the first cycle with busy low, as busy falls. An item uses at
// most MAX_TERMS terms. Reset clears the sequencer and sets the ratio to
// one half. The result is never held off by the receiver.
module takagi_curve_evaluator_core #(
  parameter int unsigned MAX_TERMS       = tce_pkg::MaxTermsDefault,
  parameter int unsigned POINT_FRAC_BITS = tce_pkg::PointFracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [POINT_FRAC_BITS-1:0]       point_i,
  output logic                             done_o,
  output logic [tce_pkg::ValueW-1:0]       curve_value_o,
  output logic [tce_pkg::CountOutW-1:0]    terms_used_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tce_pkg::ApbAddrW-1:0]     paddr,
  input  logic [tce_pkg::ApbDataW-1:0]     pwdata,
  output logic [tce_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready
);
  import tce_pkg::*;

  logic [RatioW-1:0] ratio_q;
  logic              reg_hit;
  tce_cmd_t          cmd;
  tce_status_t       status;

  assign reg_hit = (paddr[2] == REG_WEIGHT_RATIO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      ratio_q <= pwdata[RatioW-1:0];
    end
  end

  assign prdata = reg_hit ? ApbDataW'(ratio_q) : '0;
  assign pready = 1'b1;

  tce_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  tce_datapath #(
    .MAX_TERMS       (MAX_TERMS),
    .POINT_FRAC_BITS (POINT_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .point_i       (point_i),
    .ratio_i       (ratio_q),
    .curve_value_o (curve_value_o),
    .terms_used_o  (terms_used_o)
  );

endmodule

// File: sv/tce_checker.sv
`timescale 1ns / 1ps
// Port-level checks for takagi_curve_evaluator_core, bound to the top.
// Depends on tce_pkg.
module tce_checker #(
  parameter int unsigned MAX_TERMS = tce_pkg::MaxTermsDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [tce_pkg::CountOutW-1:0] terms_used_o
);
  import tce_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $fell(busy)))
    else $error("result strobe not right after busy fell");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy fell without a result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((MAX_TERMS == 64) ||
                (terms_used_o != '0 && CountW'(terms_used_o) <= CountW'(MAX_TERMS))))
    else $error("term count out of range");

endmodule

bind takagi_curve_evaluator_core tce_checker #(
  .MAX_TERMS (MAX_TERMS)
) u_tce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .terms_used_o (terms_used_o)
);

// File: verif/tb_takagi_curve_evaluator_core.sv
`timescale 1ns / 1ps
// Testbench for takagi_curve_evaluator_core: drives points and ratio writes,
// predicts each curve word in a scoreboard class. Depends on tce_pkg and the core.
module tb_takagi_curve_evaluator_core;
  import tce_pkg::*;

  localparam int unsigned MaxTerms  = MaxTermsDefault;
  localparam int unsigned PointBits = PointFracBitsDefault;
  localparam int unsigned StallLimit = 5000;
  localparam logic [63:0] ValueMax = (64'd1 << ValueW) - 64'd1;
  localparam logic [ApbAddrW-1:0] RatioAddr = {REG_WEIGHT_RATIO, 2'b00};
  localparam logic [ApbAddrW-1:0] UnmappedAddr = RatioAddr + ApbAddrW'(4);

  typedef struct {
    logic [PointBits-1:0] point;
    logic [ValueW-1:0]    value;
    logic [CountOutW-1:0] count;
  } curve_word_t;

  class takagi_scoreboard;
    logic [RatioW-1:0] ratio;
    curve_word_t       curve_q[$];
    int unsigned       failures;

    function new();
      ratio    = RatioReset;
      failures = 0;
    endfunction

    function void write_reg(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
      if (addr[ApbAddrW-1:2] == REG_WEIGHT_RATIO) ratio = data[RatioW-1:0];
    endfunction

    // Weighted triangle sum, weight in Q0.64, triangle in Q1.63, sum in Q.32.
    function curve_word_t takagi_sum(input logic [PointBits-1:0] pt);
      curve_word_t  w;
      logic [63:0]  phase, t, ramp, wt, addend, acc;
      logic [127:0] prod;
      int unsigned  used;
      phase = {pt, {(PhaseW - PointBits){1'b0}}};
      acc   = '0;
      wt    = '0;
      used  = 0;
      for (int k = 0; k < MaxTerms; k++) begin
        t    = phase << k;
        ramp = t[63] ? (64'd0 - t) : t;
        if (k == 0) begin
          addend = ramp >> 31;
        end else begin
          prod   = {64'd0, wt} * {64'd0, ramp};
          addend = prod[127:64] >> 31;
        end
        acc = acc + addend;
        if (acc > ValueMax) acc = ValueMax;
        used = k + 1;
        if (k == 0) begin
          wt = {ratio, 32'd0};
        end else begin
          prod = {64'd0, wt} * {96'd0, ratio};
          wt   = prod[95:32];
        end
        if (wt < WeightFloor) break;
      end
      w.point = pt;
      w.value = acc[ValueW-1:0];
      w.count = used[CountOutW-1:0];
      return w;
    endfunction

    function void note_point(input logic [PointBits-1:0] pt);
      curve_q.push_back(takagi_sum(pt));
    endfunction

    function void check_result(input logic [ValueW-1:0] value, input logic [CountOutW-1:0] count);
      curve_word_t w;
      if (curve_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected curve word: value %h terms %0d", value, count);
        return;
      end
      w = curve_q.pop_front();
      if (value !== w.value || count !== w.count) begin
        failures++;
        if (failures <= 10)
          $display("mismatch point %h ratio %h: expected value %h terms %0d, got value %h terms %0d",
                   w.point, ratio, w.value, w.count, value, count);
      end
    endfunction

    function int unsigned pending();
      return curve_q.size();
    endfunction
  endclass

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   start   = 1'b0;
  logic [PointBits-1:0]   point_i = '0;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [ApbAddrW-1:0]    paddr   = '0;
  logic [ApbDataW-1:0]    pwdata  = '0;
  logic                   busy;
  logic                   done_o;
  logic [ValueW-1:0]      curve_value_o;
  logic [CountOutW-1:0]   terms_used_o;
  logic [ApbDataW-1:0]    prdata;
  logic                   pready;
  int unsigned            stall_cycles = 0;
  takagi_scoreboard       sb;

  takagi_curve_evaluator_core dut (
    .clk_i, .rst_ni, .start, .busy, .point_i, .done_o, .curve_value_o, .terms_used_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(curve_value_o, terms_used_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_point(input logic [PointBits-1:0] pt);
    start   <= 1'b1;
    point_i <= pt;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sb.note_point(pt);
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [PointBits-1:0] rand_point();
    logic [PointBits-1:0] p;
    p = PointBits'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: p = ({{(PointBits - 1){1'b0}}, 1'b1} << $urandom_range(0, PointBits - 1))
             | (p >> $urandom_range(8, PointBits - 1));
      1: p = {2'b10, {(PointBits - 2){1'b0}}} ^ (p >> $urandom_range(1, PointBits - 1));
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [RatioW-1:0] phase_ratio(input int unsigned ph);
    case (ph)
      0, 4:    return $urandom;
      1:       return $urandom >> $urandom_range(0, RatioW - 1);
      2:       return {16'hFFFF, 16'($urandom)};
      3:       return RatioW'($urandom_range(0, 1));
      default: return '1;
    endcase
  endfunction

  task automatic random_points(input int unsigned n, input bit gaps);
    int unsigned sent;
    int unsigned burst;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_point(rand_point());
        sent++;
      end
      if (!paused && sent >= n / 2) begin
        drain();
        paused = 1'b1;
      end else if (gaps && $urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(1, 120));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ratio of one half: corner points
    send_point('0);
    send_point('1);
    send_point({1'b1, {(PointBits - 1){1'b0}}});
    send_point({2'b01, {(PointBits - 2){1'b0}}});
    send_point({2'b11, {(PointBits - 2){1'b0}}});
    send_point({(PointBits / 2){2'b01}});
    send_point({(PointBits / 2){2'b10}});
    send_point({{(PointBits - 1){1'b0}}, 1'b1});
    send_point({1'b0, {(PointBits - 1){1'b1}}});
    send_point({1'b1, {(PointBits - 2){1'b0}}, 1'b1});
    drain();

    // write to an unmapped register leaves the ratio alone
    apb_write(UnmappedAddr, '0);
    send_point({1'b1, {(PointBits - 1){1'b0}}});
    drain();

    // zero ratio: one term only
    apb_write(RatioAddr, '0);
    send_point(48'h1234_5678_9ABC);
    send_point('1);
    send_point({1'b1, {(PointBits - 1){1'b0}}});
    drain();

    // ratio just below one: every term is used
    apb_write(RatioAddr, '1);
    send_point({(PointBits / 2){2'b01}});
    send_point({{(PointBits - 1){1'b0}}, 1'b1});
    send_point({(PointBits / 2){2'b10}});
    drain();

    apb_write(RatioAddr, {{(ApbDataW - 1){1'b0}}, 1'b1});
    send_point(48'hFEDC_BA98_7654);
    send_point({3'b011, {(PointBits - 3){1'b1}}});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      apb_write(RatioAddr, phase_ratio(ph));
      random_points(180, ph != 0);
      drain();
    end

    repeat (110) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
